/* src/swm_pkg.sv */
// Shared types for the sliding-window median filter.
// Holds the command bundle that the sequencer sends to every sorted cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  // Per-cycle command broadcast to every cell of the sorted row.
  typedef struct packed {
    logic ins;   // insert the operand at its sorted place
    logic clr;   // with ins: drop the current contents first
    logic rem;   // remove one entry equal to the operand
    logic wipe;  // invalidate every cell
  } swm_ctl_t;

endpackage : swm_pkg

`default_nettype wire

/* src/swm_cell.sv */
// One cell of the sorted sample row.
// Holds one value and its valid flag, and trades data with both neighbors.
// Depends on swm_pkg for the command bundle.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swm_pkg::swm_ctl_t             ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] opnd_i,
  input  logic signed [SAMPLE_BITS-1:0] left_val_i,
  input  logic                          left_vld_i,
  input  logic                          left_cond_i,
  input  logic signed [SAMPLE_BITS-1:0] right_val_i,
  input  logic                          right_vld_i,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic                          vld_o,
  output logic                          cond_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic                          vld_q, vld_d;
  logic                          vld_eff;
  logic                          ins_cond;
  logic                          rem_cond;

  // A start of a new sequence makes the whole row look empty.
  assign vld_eff  = vld_q & ~ctl_i.clr;
  assign ins_cond = ~vld_eff | (val_q > opnd_i);
  // Shift left from the last entry equal to the removed value onward.
  assign rem_cond = ~vld_eff | (val_q > opnd_i) |
                    ((val_q == opnd_i) & ~(right_vld_i & (right_val_i == opnd_i)));

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctl_i.wipe) begin
      vld_d = 1'b0;
    end else if (ctl_i.ins) begin
      if (left_cond_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else if (ins_cond) begin
        val_d = opnd_i;
        vld_d = 1'b1;
      end else begin
        vld_d = vld_eff;
      end
    end else if (ctl_i.rem) begin
      if (rem_cond) begin
        val_d = right_val_i;
        vld_d = right_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign vld_o  = vld_eff;
  assign cond_o = ins_cond;

endmodule : swm_cell

`default_nettype wire

/* src/sliding_window_median.sv */
// Sliding-window median filter: top level with sequencer, arrival ring and sorted cell row.
// Depends on swm_pkg and swm_cell.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, sample_i,          | to block
//           | start_new_i                               |
//   out     | out_valid_o, out_stall_i, median_doubled_o | from block
//   cfg     | cfg_we_i, cfg_wdata_i                     | to block
//
// Each item is first inserted into the sorted row in S_IDLE; in S_UPDATE, once the
// window is full, the median is read and the oldest sample retired. The row changes
// by one operation per cycle. If the window is full and the previous result has not
// been taken, S_UPDATE waits until the output register frees up. After reset the
// window is empty and window_length is 3; a write to window_length empties it too.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          start_new_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS:0]   median_doubled_o,
  input  logic                          cfg_we_i,
  input  logic [6:0]                    cfg_wdata_i
);
  import swm_pkg::*;

  localparam int unsigned LW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned OW = SAMPLE_BITS + 1;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e                        state_q;
  logic [6:0]                    wl_q;
  logic [LW-1:0]                 fill_q;
  logic [PW-1:0]                 oldest_q;
  logic                          out_vld_q;
  logic signed [OW-1:0]          med_q;
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic                          byp_q;

  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];

  logic [LW-1:0]                 len;
  logic [LW-1:0]                 fill_eff;
  logic [PW-1:0]                 oldest_eff;
  logic [PW:0]                   wr_sum;
  logic [PW-1:0]                 wr_idx;
  logic [PW:0]                   oldest_inc;
  logic [PW-1:0]                 idx_lo;
  logic [PW-1:0]                 idx_hi;
  logic signed [OW-1:0]          med_sum;
  logic signed [SAMPLE_BITS-1:0] rem_val;
  logic                          accept;
  logic                          full;
  logic                          out_free;
  logic                          do_rem;
  swm_ctl_t                      ctl;
  logic signed [SAMPLE_BITS-1:0] opnd;

  logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         cell_vld;
  logic [MAX_WINDOW-1:0]         cell_cond;

  // Effective length: zero acts as one, oversize values clamp to the row length.
  always_comb begin
    if (wl_q == 7'd0) begin
      len = LW'(1);
    end else if (32'(wl_q) > 32'(MAX_WINDOW)) begin
      len = LW'(MAX_WINDOW);
    end else begin
      len = LW'(wl_q);
    end
  end

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign fill_eff   = start_new_i ? '0 : fill_q;
  assign oldest_eff = start_new_i ? '0 : oldest_q;

  // oldest + fill stays below twice the length, so one subtract wraps it.
  assign wr_sum = {1'b0, oldest_eff} + (PW + 1)'(fill_eff);
  assign wr_idx = (wr_sum >= (PW + 1)'(len)) ? PW'(wr_sum - (PW + 1)'(len)) : PW'(wr_sum);
  assign oldest_inc = {1'b0, oldest_q} + (PW + 1)'(1);

  assign full     = (fill_q == len);
  assign out_free = ~out_vld_q | ~out_stall_i;
  assign do_rem   = (state_q == S_UPDATE) & full & out_free;

  assign idx_lo  = PW'((len - LW'(1)) >> 1);
  assign idx_hi  = PW'(len >> 1);
  assign med_sum = {cell_val[idx_lo][SAMPLE_BITS-1], cell_val[idx_lo]} +
                   {cell_val[idx_hi][SAMPLE_BITS-1], cell_val[idx_hi]};

  // With an empty window the sample just written is also the oldest one.
  assign rem_val = byp_q ? smp_q : old_q;

  always_comb begin
    ctl      = '0;
    ctl.ins  = accept;
    ctl.clr  = accept & start_new_i;
    ctl.rem  = do_rem;
    ctl.wipe = cfg_we_i;
  end

  assign opnd = accept ? sample_i : rem_val;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lval;
    logic                          lvld;
    logic                          lcond;
    logic signed [SAMPLE_BITS-1:0] rval;
    logic                          rvld;

    if (k == 0) begin : g_first
      assign lval  = '0;
      assign lvld  = 1'b0;
      assign lcond = 1'b0;
    end else begin : g_mid_l
      assign lval  = cell_val[k-1];
      assign lvld  = cell_vld[k-1];
      assign lcond = cell_cond[k-1];
    end

    if (k == MAX_WINDOW - 1) begin : g_last
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rval = cell_val[k+1];
      assign rvld = cell_vld[k+1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .opnd_i     (opnd),
      .left_val_i (lval),
      .left_vld_i (lvld),
      .left_cond_i(lcond),
      .right_val_i(rval),
      .right_vld_i(rvld),
      .val_o      (cell_val[k]),
      .vld_o      (cell_vld[k]),
      .cond_o     (cell_cond[k])
    );
  end

  // Arrival ring: written with each item, oldest entry read alongside.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_mem[wr_idx] <= sample_i;
      old_q            <= hist_mem[oldest_eff];
      smp_q            <= sample_i;
      byp_q            <= (fill_eff == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wl_q      <= 7'd3;
      fill_q    <= '0;
      oldest_q  <= '0;
      out_vld_q <= 1'b0;
      med_q     <= '0;
    end else begin
      // A new result may replace one that is taken in the same cycle.
      if (do_rem) begin
        med_q     <= med_sum;
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        wl_q     <= cfg_wdata_i;
        fill_q   <= '0;
        oldest_q <= '0;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (accept) begin
              fill_q   <= fill_eff + LW'(1);
              oldest_q <= oldest_eff;
              state_q  <= S_UPDATE;
            end
          end
          S_UPDATE: begin
            if (!full) begin
              state_q <= S_IDLE;
            end else if (out_free) begin
              fill_q   <= fill_q - LW'(1);
              oldest_q <= (oldest_inc >= (PW + 1)'(len)) ? '0 : PW'(oldest_inc);
              state_q  <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign median_doubled_o = med_q;

`ifndef SYNTHESIS
  // Valid cells always form a prefix of the row.
  a_vld_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_vld & (cell_vld + 1'b1)) == '0)
    else $error("sorted row has a gap between valid cells");

  // The row holds exactly as many entries as the fill count says, except while
  // a restart makes the row look empty.
  a_fill_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clr || ($countones(cell_vld) == int'(fill_q)))
    else $error("valid cell count differs from fill count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len)
    else $error("fill count exceeds window length");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW + 1)'(oldest_q) < (PW + 1)'(len) || fill_q == '0)
    else $error("oldest pointer outside the window");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(med_q)))
    else $error("pending result was overwritten or dropped");
`endif

endmodule : sliding_window_median

`default_nettype wire

/* bench/sliding_window_median_tb.sv */
// Self-checking testbench for the sliding-window median filter.
// Drives samples and window lengths, predicts the doubled median of each full window
// and compares every result in order. Depends only on sliding_window_median.
`timescale 1ns / 1ps

module sliding_window_median_tb;

  localparam int unsigned MAX_WINDOW  = 64;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_GOAL = 1520;
  localparam int unsigned STEADY_ITEMS = 230;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PRINT_CAP = 40;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          start_new_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [SAMPLE_BITS:0]   median_doubled_o;
  logic                          cfg_we_i;
  logic [6:0]                    cfg_wdata_i;

  // Window state mirrored by the predictor.
  logic signed [SAMPLE_BITS-1:0] ordered_window [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] arrival_ring [MAX_WINDOW];
  int unsigned                   held_count;
  int unsigned                   oldest_slot;
  logic [6:0]                    window_length;

  logic signed [SAMPLE_BITS:0]   pending_medians [$];
  int unsigned                   mismatch_count;
  int unsigned                   items_sent;
  int unsigned                   cycle_count;
  logic                          idle_on;

  logic [6:0] length_menu [12] = '{7'd1, 7'd2, 7'd64, 7'd5, 7'd127, 7'd8,
                                   7'd0, 7'd4, 7'd65, 7'd7, 7'd3, 7'd16};

  sliding_window_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .start_new_i     (start_new_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .median_doubled_o(median_doubled_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_length(input logic [6:0] len);
    if (len == 7'd0) return 1;
    if (len > MAX_WINDOW) return MAX_WINDOW;
    return 32'(len);
  endfunction

  // Inserts one sample into the mirrored window and queues the median when full.
  task automatic window_push(input logic signed [SAMPLE_BITS-1:0] s, input logic fresh);
    int unsigned len;
    int unsigned wr;
    int unsigned pos;
    int unsigned i;
    logic signed [SAMPLE_BITS-1:0] gone;
    logic signed [SAMPLE_BITS:0] lo;
    logic signed [SAMPLE_BITS:0] hi;
    len = effective_length(window_length);
    if (fresh) begin
      held_count = 0;
      oldest_slot = 0;
    end
    wr = oldest_slot + held_count;
    if (wr >= len) wr -= len;
    arrival_ring[wr] = s;
    pos = 0;
    while (pos < held_count && ordered_window[pos] <= s) pos++;
    for (i = held_count; i > pos; i--) ordered_window[i] = ordered_window[i-1];
    ordered_window[pos] = s;
    held_count++;
    if (held_count >= len) begin
      lo = (SAMPLE_BITS + 1)'(ordered_window[(len-1)/2]);
      hi = (SAMPLE_BITS + 1)'(ordered_window[len/2]);
      pending_medians.push_back(lo + hi);
      // The oldest sample leaves both copies; the first equal sorted entry goes.
      gone = arrival_ring[oldest_slot];
      pos = 0;
      while (pos < held_count && ordered_window[pos] != gone) pos++;
      for (i = pos; i + 1 < held_count; i++) ordered_window[i] = ordered_window[i+1];
      held_count--;
      oldest_slot++;
      if (oldest_slot >= len) oldest_slot = 0;
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Sends one item and holds it until accepted, with an optional gap first.
  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input logic fresh);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    start_new_i <= fresh;
    do @(posedge clk_i); while (in_stall_o);
    window_push(s, fresh);
    items_sent++;
  endtask

  // Waits for the block to go idle, then writes the window length.
  task automatic set_window_length(input logic [6:0] len);
    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_length = len;
    held_count = 0;
    oldest_slot = 0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      1, 2, 3: return $signed(16'($urandom_range(0, 6)) - 16'd3);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic test_default_length();
    idle_on = 1'b0;
    send_item(16'sd32767, 1'b0);
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd0, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(16'sd5, 1'b0);
    send_item(16'sd5, 1'b0);
    send_item(16'sd5, 1'b0);
    // A restart in the middle of a window must drop the older samples.
    send_item(-16'sd7, 1'b1);
    send_item(16'sd9, 1'b0);
    send_item(16'sd2, 1'b0);
    send_item(-16'sd32768, 1'b0);
  endtask

  task automatic test_short_lengths();
    // A length of zero behaves as a window of one.
    set_window_length(7'd0);
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd32767, 1'b1);
    send_item(16'sd1, 1'b0);
    set_window_length(7'd2);
    send_item(-16'sd32768, 1'b0);
    send_item(-16'sd32768, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(16'sd32767, 1'b0);
    send_item(-16'sd1, 1'b1);
    send_item(16'sd0, 1'b0);
    send_item(16'sd32767, 1'b0);
  endtask

  task automatic test_random_windows();
    int unsigned phase;
    int unsigned len;
    int unsigned count;
    logic [6:0] wl;
    phase = 0;
    while (items_sent < RANDOM_GOAL) begin
      if (phase < 12) wl = length_menu[phase];
      else if ($urandom_range(0, 4) == 0) wl = 7'($urandom_range(0, 127));
      else wl = 7'($urandom_range(0, 12));
      set_window_length(wl);
      idle_on = ($urandom_range(0, 3) != 0);
      len = effective_length(wl);
      count = (len >= 32) ? 180 : $urandom_range(40, 110);
      repeat (count) send_item(pick_sample(), $urandom_range(0, 3 * len + 30) == 0);
      phase++;
    end
  endtask

  task automatic test_steady_stream();
    int unsigned len;
    set_window_length(7'($urandom_range(1, 9)));
    idle_on = 1'b0;
    len = effective_length(window_length);
    repeat (STEADY_ITEMS) send_item(pick_sample(), $urandom_range(0, 3 * len + 30) == 0);
  endtask

  // Result stall in random bursts, silent during the final stretch.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    logic signed [SAMPLE_BITS:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected", median_doubled_o));
      end else begin
        want = pending_medians.pop_front();
        if (median_doubled_o !== want) begin
          report_mismatch($sformatf("median_doubled got %0d, want %0d",
                                    median_doubled_o, want));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    start_new_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    idle_on = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    cycle_count = 0;
    window_length = 7'd3;
    held_count = 0;
    oldest_slot = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_length();
    test_short_lengths();
    test_random_windows();
    test_steady_stream();

    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
